// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the priority ready queue core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled while reset is active.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a signal is never unknown while reset is released.
`define ASSERT_KNOWN(label, clk, rst_n, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !$isunknown(sig)) \
        else $error(msg);

`endif

// ===== hw/rtl/prq_pkg.sv =====
package prq_pkg;

    localparam int NumTasksDefault = 32;
    localparam int NumPrioritiesDefault = 32;
    localparam int TaskW = 5;
    localparam int PrioW = 5;
    localparam int CmdW = 3;
    localparam int StatusW = 2;
    localparam int FlagsW = 32;

    typedef enum logic [CmdW-1:0] {
        CMD_REGISTER = 3'd0,
        CMD_DELETE   = 3'd1,
        CMD_DISCARD  = 3'd2,
        CMD_SUSPEND  = 3'd3,
        CMD_RECOVER  = 3'd4,
        CMD_PICK     = 3'd5,
        CMD_RSVD6    = 3'd6,
        CMD_RSVD7    = 3'd7
    } cmd_t;

    typedef enum logic [StatusW-1:0] {
        STAT_OK        = 2'd0,
        STAT_WRONG     = 2'd1,
        STAT_NONE      = 2'd2,
        STAT_RSVD      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        TS_DEAD  = 2'd0,
        TS_READY = 2'd1,
        TS_SUSP  = 2'd2,
        TS_RSVD  = 2'd3
    } tstate_t;

endpackage

// ===== hw/rtl/priority_ready_queue_core.sv =====
// Priority ready queue: one FIFO of task numbers per priority plus a bitmap.
// Input channel s_axis: tdata carries command, task_id and priority_req.
// Output channel m_axis: tdata carries status, picked_task and ready_flags.
// Each command is taken in the IDLE state and runs through a short sequencer
// that reads the link memories (registered read), then writes back
// the changed pointers, one memory port access per memory each cycle.
// A command that changes no list goes from DEC to DONE; a pick that finds
// a task passes PICK; an unlink passes UL_RD, UL_WA and UL_WB, a link
// passes AP_RD, AP_WA and AP_WB, and a recover of a listed task does both.
// A new command is accepted only in IDLE, once the last one has left DONE.
// One command is in work at a time; the next is taken once the result has
// moved into the output register, so a result may wait while the next
// command is accepted and worked.
// Reset clears the bitmap, all task states to dead and all queued flags;
// the head, tail, link and priority memories need no clearing.
// When the receiver stalls, the finished result holds in the output
// register, and the sequencer waits before loading another result into it.
module priority_ready_queue_core #(
    parameter int NUM_TASKS = prq_pkg::NumTasksDefault,
    parameter int NUM_PRIORITIES = prq_pkg::NumPrioritiesDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command[2:0], task_id[7:3], priority_req[12:8], zeros[15:13]
    input  logic [15:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], picked_task[6:2], ready_flags[38:7], zeros[39]
    output logic [39:0] m_axis_tdata
);

    import prq_pkg::*;

    `include "assert_macros.svh"

    localparam int TIW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int PIW = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_UL_RD, S_UL_WA, S_UL_WB, S_AP_RD, S_AP_WA, S_AP_WB,
        S_PICK, S_DONE
    } state_t;

    state_t state_reg;
    cmd_t cmd_reg;
    logic [TaskW-1:0] tid_reg;
    logic [PrioW-1:0] prio_reg;
    logic [NUM_PRIORITIES-1:0] bitmap_reg;
    tstate_t tstate_reg [NUM_TASKS];
    logic [NUM_TASKS-1:0] inlist_reg;
    logic do_append_reg;
    logic [StatusW-1:0] status_reg;
    logic [TaskW-1:0] picked_reg;
    logic [TIW-1:0] nx_reg, pv_reg;
    logic [PIW-1:0] lp_reg;
    logic out_valid_reg;
    logic [39:0] out_data_reg;

    // Memory ports.
    logic hd_we, tl_we, nx_we, pv_we, pr_we;
    logic [PIW-1:0] hd_wa, tl_wa, hd_ra, tl_ra;
    logic [TIW-1:0] nx_wa, pv_wa, nx_ra, pv_ra, pr_wa, pr_ra;
    logic [TIW-1:0] hd_wd, tl_wd, nx_wd, pv_wd;
    logic [PIW-1:0] pr_wd;
    logic [TIW-1:0] hd_rd, tl_rd, nx_rd, pv_rd;
    logic [PIW-1:0] pr_rd;

    prq_ram #(.Width(TIW), .Depth(NUM_PRIORITIES)) u_head (.clk(clk), .we(hd_we),
        .waddr(hd_wa), .wdata(hd_wd), .raddr(hd_ra), .rdata(hd_rd));
    prq_ram #(.Width(TIW), .Depth(NUM_PRIORITIES)) u_tail (.clk(clk), .we(tl_we),
        .waddr(tl_wa), .wdata(tl_wd), .raddr(tl_ra), .rdata(tl_rd));
    prq_ram #(.Width(TIW), .Depth(NUM_TASKS)) u_next (.clk(clk), .we(nx_we),
        .waddr(nx_wa), .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd));
    prq_ram #(.Width(TIW), .Depth(NUM_TASKS)) u_prev (.clk(clk), .we(pv_we),
        .waddr(pv_wa), .wdata(pv_wd), .raddr(pv_ra), .rdata(pv_rd));
    prq_ram #(.Width(PIW), .Depth(NUM_TASKS)) u_prio (.clk(clk), .we(pr_we),
        .waddr(pr_wa), .wdata(pr_wd), .raddr(pr_ra), .rdata(pr_rd));

    logic [TIW-1:0] t_idx;
    logic tid_ok;
    logic [PIW-1:0] req_p;
    logic [PIW-1:0] first_p;
    logic first_found;
    logic [PrioW:0] prio_sat;
    logic ul_only, ul_is_head, ul_is_tail;
    logic [TIW-1:0] ul_t_ext;

    assign t_idx = TIW'(tid_reg);
    assign tid_ok = ({4'b0, tid_reg} < 9'(NUM_TASKS));
    assign prio_sat = (6'(prio_reg) >= 6'(NUM_PRIORITIES)) ? 6'(NUM_PRIORITIES - 1)
                                                            : 6'(prio_reg);
    assign req_p = prio_sat[PIW-1:0];
    assign ul_t_ext = t_idx;
    assign ul_only = (hd_rd == ul_t_ext) && (tl_rd == ul_t_ext);
    assign ul_is_head = (hd_rd == ul_t_ext);
    assign ul_is_tail = (tl_rd == ul_t_ext);

    // Lowest set bit of the bitmap.
    always_comb
    begin
        first_p = '0;
        first_found = 1'b0;
        for (int i = NUM_PRIORITIES - 1; i >= 0; i--)
        begin
            if (bitmap_reg[i])
            begin
                first_p = PIW'(i);
                first_found = 1'b1;
            end
        end
    end

    // Memory addressing and write data per sequencer step.
    always_comb
    begin
        hd_we = 1'b0; tl_we = 1'b0; nx_we = 1'b0; pv_we = 1'b0; pr_we = 1'b0;
        hd_wa = lp_reg; tl_wa = lp_reg; hd_ra = lp_reg; tl_ra = lp_reg;
        nx_wa = t_idx; pv_wa = t_idx; nx_ra = t_idx; pv_ra = t_idx;
        pr_wa = t_idx; pr_ra = t_idx; pr_wd = req_p;
        hd_wd = t_idx; tl_wd = t_idx; nx_wd = t_idx; pv_wd = t_idx;
        unique case (state_reg)
            S_DEC:
            begin
                pr_we = (cmd_reg == CMD_REGISTER) && tid_ok && !inlist_reg[t_idx];
            end
            S_UL_RD:
            begin
                hd_ra = pr_rd; tl_ra = pr_rd;
            end
            S_UL_WA:
            begin
                if (!ul_only)
                begin
                    if (ul_is_head)
                    begin
                        hd_we = 1'b1; hd_wd = nx_rd;
                    end
                    else
                    begin
                        nx_we = 1'b1; nx_wa = pv_rd; nx_wd = nx_rd;
                    end
                end
            end
            S_UL_WB:
            begin
                if (!ul_only)
                begin
                    if (ul_is_tail)
                    begin
                        tl_we = 1'b1; tl_wd = pv_reg;
                    end
                    else
                    begin
                        pv_we = 1'b1; pv_wa = nx_reg; pv_wd = pv_reg;
                    end
                end
            end
            S_AP_RD:
            begin
                // A recovered task's priority is only now out of the memory.
                hd_ra = lp_reg;
                tl_ra = (cmd_reg == CMD_RECOVER) ? pr_rd : lp_reg;
            end
            S_AP_WA:
            begin
                tl_we = 1'b1; tl_wd = t_idx;
                nx_we = 1'b1; nx_wa = t_idx; nx_wd = t_idx;
                pv_we = 1'b1; pv_wa = t_idx;
                if (!bitmap_reg[lp_reg])
                begin
                    hd_we = 1'b1; hd_wd = t_idx; pv_wd = t_idx;
                end
                else
                begin
                    pv_wd = tl_rd;
                end
            end
            S_AP_WB:
            begin
                if (nx_reg != t_idx)
                begin
                    nx_we = 1'b1; nx_wa = nx_reg; nx_wd = t_idx;
                end
            end
            S_PICK, S_DONE:
            begin
                // Keep the picked head on the read port while the result waits.
                hd_ra = first_p;
            end
            default:
            begin
            end
        endcase
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;

    // Sequencer, state tables and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            bitmap_reg <= '0;
            inlist_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                tstate_reg[i] <= TS_DEAD;
            end
        end
        else
        begin
            // Load a finished result, or drop valid after its transfer.
            if (state_reg == S_DONE && (!out_valid_reg || m_axis_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tvalid && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        cmd_reg <= cmd_t'(s_axis_tdata[2:0]);
                        tid_reg <= s_axis_tdata[7:3];
                        prio_reg <= s_axis_tdata[12:8];
                        state_reg <= S_DEC;
                    end
                end
                S_DEC:
                begin
                    picked_reg <= '0;
                    do_append_reg <= (cmd_reg == CMD_RECOVER) && tid_ok
                                     && (tstate_reg[t_idx] == TS_SUSP);
                    if (cmd_reg == CMD_PICK)
                    begin
                        if (!first_found)
                        begin
                            status_reg <= STAT_NONE;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            status_reg <= STAT_OK;
                            state_reg <= S_PICK;
                        end
                    end
                    else if (cmd_reg == CMD_RSVD6 || cmd_reg == CMD_RSVD7)
                    begin
                        status_reg <= STAT_OK;
                        state_reg <= S_DONE;
                    end
                    else if (!tid_ok)
                    begin
                        status_reg <= STAT_WRONG;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        case (cmd_reg)
                            CMD_REGISTER:
                            begin
                                if (inlist_reg[t_idx])
                                begin
                                    status_reg <= STAT_WRONG;
                                    state_reg <= S_DONE;
                                end
                                else
                                begin
                                    status_reg <= STAT_OK;
                                    tstate_reg[t_idx] <= TS_READY;
                                    lp_reg <= req_p;
                                    state_reg <= S_AP_RD;
                                end
                            end
                            CMD_DELETE, CMD_DISCARD:
                            begin
                                status_reg <= STAT_OK;
                                if (cmd_reg == CMD_DELETE)
                                begin
                                    tstate_reg[t_idx] <= TS_DEAD;
                                end
                                if (inlist_reg[t_idx])
                                begin
                                    state_reg <= S_UL_RD;
                                end
                                else
                                begin
                                    state_reg <= S_DONE;
                                end
                            end
                            CMD_SUSPEND:
                            begin
                                if (tstate_reg[t_idx] != TS_READY)
                                begin
                                    status_reg <= STAT_WRONG;
                                    state_reg <= S_DONE;
                                end
                                else
                                begin
                                    status_reg <= STAT_OK;
                                    tstate_reg[t_idx] <= TS_SUSP;
                                    if (inlist_reg[t_idx])
                                    begin
                                        state_reg <= S_UL_RD;
                                    end
                                    else
                                    begin
                                        state_reg <= S_DONE;
                                    end
                                end
                            end
                            default:
                            begin
                                if (tstate_reg[t_idx] != TS_SUSP)
                                begin
                                    status_reg <= STAT_WRONG;
                                    state_reg <= S_DONE;
                                end
                                else
                                begin
                                    status_reg <= STAT_OK;
                                    tstate_reg[t_idx] <= TS_READY;
                                    state_reg <= inlist_reg[t_idx] ? S_UL_RD : S_AP_RD;
                                end
                            end
                        endcase
                    end
                end
                S_UL_RD:
                begin
                    // Priority, next and prev of the task are valid now.
                    lp_reg <= pr_rd;
                    nx_reg <= nx_rd;
                    pv_reg <= pv_rd;
                    state_reg <= S_UL_WA;
                end
                S_UL_WA:
                begin
                    if (ul_only)
                    begin
                        bitmap_reg[lp_reg] <= 1'b0;
                    end
                    inlist_reg[t_idx] <= 1'b0;
                    state_reg <= S_UL_WB;
                end
                S_UL_WB:
                begin
                    if (do_append_reg)
                    begin
                        state_reg <= S_AP_RD;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_AP_RD:
                begin
                    if (cmd_reg == CMD_RECOVER)
                    begin
                        lp_reg <= pr_rd;
                    end
                    state_reg <= S_AP_WA;
                end
                S_AP_WA:
                begin
                    nx_reg <= bitmap_reg[lp_reg] ? tl_rd : t_idx;
                    bitmap_reg[lp_reg] <= 1'b1;
                    inlist_reg[t_idx] <= 1'b1;
                    state_reg <= S_AP_WB;
                end
                S_AP_WB:
                begin
                    state_reg <= S_DONE;
                end
                S_PICK:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_data_reg <= {1'b0, FlagsW'(bitmap_reg),
                            (cmd_reg == CMD_PICK && status_reg == STAT_OK)
                                ? TaskW'(hd_rd) : picked_reg, status_reg};
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `ASSERT_CLK(a_one_busy, clk, rst_n,
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == S_DEC), "accept must start decode")
    `ASSERT_CLK(a_ready_idle, clk, rst_n,
        (state_reg != S_IDLE) |-> !s_axis_tready, "ready while busy")
    `ASSERT_CLK(a_done_out, clk, rst_n,
        (state_reg == S_DONE && m_axis_tready) |=> m_axis_tvalid, "result lost")
    `ASSERT_KNOWN(a_known_valid, clk, rst_n, m_axis_tvalid, "output valid unknown")

endmodule

// ===== hw/rtl/prq_ram.sv =====
module prq_ram #(
    parameter int Width = 8,
    parameter int Depth = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    // Synchronous write, registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
